// ===== design/rsdz_pkg.sv =====
// ---------------------------------------------------------------------------
// rsdz_pkg
// Shared types, constants and per-stage step functions for the radial
// stick dead zone pipeline.
// ---------------------------------------------------------------------------
package rsdz_pkg;

    localparam int unsigned RootBits = 16;
    localparam int unsigned QuoBits  = 16;
    localparam logic [14:0] AXIS_MAX     = 15'd32767;
    localparam logic [14:0] RADIUS_RESET = 15'd7849;

    // One stage of the digit-by-digit square root
    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] stick_x;
        logic [15:0] stick_y;
        logic [31:0] rad;
        logic [16:0] rem;
        logic [15:0] root;
    } sqrt_stage_t;

    // One lane of a restoring divider
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] feed;
        logic [15:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic [1:0]      pad;
        logic            neg_x;
        logic            neg_y;
        logic            zero;
        logic            act;
        logic [15:0]     root;
        logic [14:0]     den;
        div_lane_t [2:0] lane;
    } div_stage_t;

    // Bring down two radicand bits and resolve one root bit
    function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t s);
        sqrt_stage_t n;
        logic [18:0] r2;
        logic [18:0] t;
        logic        ge;
        n  = s;
        r2 = {s.rem, s.rad[31:30]};
        t  = {1'b0, s.root, 2'b01};
        ge = (r2 >= t);
        n.rem  = ge ? 17'(r2 - t) : 17'(r2);
        n.root = {s.root[14:0], ge};
        n.rad  = {s.rad[29:0], 2'b00};
        return n;
    endfunction

    // Bring down one dividend bit and resolve one quotient bit
    function automatic div_lane_t div_step(input div_lane_t l, input logic [15:0] d);
        div_lane_t   n;
        logic [16:0] r2;
        logic        ge;
        r2 = {l.rem, l.feed[15]};
        ge = (r2 >= {1'b0, d});
        n.rem  = ge ? 16'(r2 - {1'b0, d}) : 16'(r2);
        n.feed = {l.feed[14:0], 1'b0};
        n.quo  = {l.quo[14:0], ge};
        return n;
    endfunction

endpackage

// ===== design/rsdz_if.sv =====
// ---------------------------------------------------------------------------
// rsdz_sample_if / rsdz_result_if
// Valid/ready channels carrying stick samples and processed results.
// ---------------------------------------------------------------------------
interface rsdz_sample_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pad;
    logic [15:0] stick_x;
    logic [15:0] stick_y;
    modport source (output valid, pad, stick_x, stick_y, input ready);
    modport sink   (input valid, pad, stick_x, stick_y, output ready);
endinterface

interface rsdz_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pad_out;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] strength;
    modport source (output valid, pad_out, dir_x, dir_y, strength, input ready);
    modport sink   (input valid, pad_out, dir_x, dir_y, strength, output ready);
endinterface

// ===== design/radial_stick_dead_zone.sv =====
// ---------------------------------------------------------------------------
// radial_stick_dead_zone
// Radial dead zone: unit direction and normalized strength of a stick sample.
// ---------------------------------------------------------------------------
// Usage:
//   sample  : valid/ready sink carrying pad, stick_x, stick_y.
//   result  : valid/ready source carrying pad_out, dir_x, dir_y, strength.
//   cfg_we / cfg_wdata : write the dead zone radius; change it only while
//     no sample is in flight.
// Pipeline: 37 register stages, the first loaded at the transfer: input
//   register, squaring, sum, 16 square root stages, divider setup,
//   16 divider stages, output register.
// Throughput: one sample per cycle while the output is not stalled; the square root and the three dividers
//   are fully pipelined, one bit per stage.
// Reset: all stage valid bits clear, radius returns to 7849.
// Stall: while a result waits and result.ready is low, the whole pipeline
//   holds and sample.ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module radial_stick_dead_zone
    import rsdz_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rsdz_sample_if.sink   sample,
    rsdz_result_if.source result,
    input  logic          cfg_we,
    input  logic [14:0]   cfg_wdata
);

    localparam int unsigned SqN  = RootBits;
    localparam int unsigned DivN = QuoBits;

    logic [14:0] dz_reg;
    logic        en;

    logic        v0_reg, v1_reg, vout_reg;
    logic [SqN:0]  vsq_reg;
    logic [DivN:0] vdiv_reg;

    logic [1:0]  pad0_reg, pad1_reg;
    logic [15:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [30:0] xx_reg, yy_reg;
    logic signed [31:0] xsq_w, ysq_w;

    sqrt_stage_t sq_reg [SqN+1];
    div_stage_t  dv_reg [DivN+1];
    div_stage_t  dv_next [DivN];

    div_stage_t  prep_next;
    logic [15:0] root_w;
    logic [14:0] mag_w;
    logic [15:0] ax_w, ay_w;
    logic [14:0] num_w;

    logic [15:0] dx_next, dy_next, st_next;
    logic [1:0]  pad_out_reg;
    logic [15:0] dir_x_reg, dir_y_reg, strength_reg;

    // advance all stages unless a result is held
    assign en           = !vout_reg || result.ready;
    assign sample.ready = en;

    // square both axes at full product width
    assign xsq_w = $signed(x0_reg) * $signed(x0_reg);
    assign ysq_w = $signed(y0_reg) * $signed(y0_reg);

    // radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            dz_reg <= cfg_wdata;
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            vsq_reg  <= '0;
            vdiv_reg <= '0;
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg   <= sample.valid;
            v1_reg   <= v0_reg;
            vsq_reg  <= {vsq_reg[SqN-1:0], v1_reg};
            vdiv_reg <= {vdiv_reg[DivN-1:0], vsq_reg[SqN]};
            vout_reg <= vdiv_reg[DivN];
        end
    end

    // divider setup: magnitudes, clamped radius, strength numerator
    always_comb
    begin
        root_w = sq_reg[SqN].root;
        mag_w  = root_w[15] ? AXIS_MAX : root_w[14:0];
        ax_w   = sq_reg[SqN].stick_x[15] ? 16'(-sq_reg[SqN].stick_x) : sq_reg[SqN].stick_x;
        ay_w   = sq_reg[SqN].stick_y[15] ? 16'(-sq_reg[SqN].stick_y) : sq_reg[SqN].stick_y;
        prep_next.pad   = sq_reg[SqN].pad;
        prep_next.neg_x = sq_reg[SqN].stick_x[15];
        prep_next.neg_y = sq_reg[SqN].stick_y[15];
        prep_next.zero  = (root_w == 16'd0);
        prep_next.act   = (mag_w > dz_reg);
        prep_next.root  = root_w;
        prep_next.den   = AXIS_MAX - dz_reg;
        num_w = prep_next.act ? 15'(mag_w - dz_reg) : 15'd0;
        prep_next.lane[0] = '{rem: {1'b0, ax_w[15:1]}, feed: {ax_w[0], 15'd0}, quo: 16'd0};
        prep_next.lane[1] = '{rem: {1'b0, ay_w[15:1]}, feed: {ay_w[0], 15'd0}, quo: 16'd0};
        prep_next.lane[2] = '{rem: {2'b00, num_w[14:1]}, feed: {num_w[0], 15'd0},
                              quo: 16'd0};
    end

    // resolve one quotient bit per lane in each divider stage
    always_comb
    begin
        for (int i = 0; i < DivN; i++)
        begin
            dv_next[i]         = dv_reg[i];
            dv_next[i].lane[0] = div_step(dv_reg[i].lane[0], dv_reg[i].root);
            dv_next[i].lane[1] = div_step(dv_reg[i].lane[1], dv_reg[i].root);
            dv_next[i].lane[2] = div_step(dv_reg[i].lane[2], {1'b0, dv_reg[i].den});
        end
    end

    // saturate, restore sign, mask special cases
    always_comb
    begin
        dx_next = (dv_reg[DivN].lane[0].quo[15]) ? 16'd32767 : dv_reg[DivN].lane[0].quo;
        dy_next = (dv_reg[DivN].lane[1].quo[15]) ? 16'd32767 : dv_reg[DivN].lane[1].quo;
        if (dv_reg[DivN].neg_x)
        begin
            dx_next = 16'(-dx_next);
        end
        if (dv_reg[DivN].neg_y)
        begin
            dy_next = 16'(-dy_next);
        end
        if (dv_reg[DivN].zero)
        begin
            dx_next = 16'd0;
            dy_next = 16'd0;
        end
        st_next = dv_reg[DivN].act ? dv_reg[DivN].lane[2].quo : 16'd0;
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pad0_reg <= sample.pad;
            x0_reg   <= sample.stick_x;
            y0_reg   <= sample.stick_y;

            pad1_reg <= pad0_reg;
            x1_reg   <= x0_reg;
            y1_reg   <= y0_reg;
            xx_reg   <= xsq_w[30:0];
            yy_reg   <= ysq_w[30:0];

            sq_reg[0].pad     <= pad1_reg;
            sq_reg[0].stick_x <= x1_reg;
            sq_reg[0].stick_y <= y1_reg;
            sq_reg[0].rad     <= {1'b0, xx_reg} + {1'b0, yy_reg};
            sq_reg[0].rem     <= 17'd0;
            sq_reg[0].root    <= 16'd0;
            for (int i = 0; i < SqN; i++)
            begin
                sq_reg[i+1] <= sqrt_step(sq_reg[i]);
            end

            dv_reg[0] <= prep_next;
            for (int i = 0; i < DivN; i++)
            begin
                dv_reg[i+1] <= dv_next[i];
            end

            pad_out_reg  <= dv_reg[DivN].pad;
            dir_x_reg    <= dx_next;
            dir_y_reg    <= dy_next;
            strength_reg <= st_next;
        end
    end

    assign result.valid    = vout_reg;
    assign result.pad_out  = pad_out_reg;
    assign result.dir_x    = dir_x_reg;
    assign result.dir_y    = dir_y_reg;
    assign result.strength = strength_reg;

endmodule

// ===== tb/radial_stick_dead_zone_tb.sv =====
// ---------------------------------------------------------------------------
// radial_stick_dead_zone_tb
// Drives stick samples through the radial dead zone block over valid/ready
// channels with random idling on both sides, predicts direction and
// strength per sample and compares every result in order.
// ---------------------------------------------------------------------------
module radial_stick_dead_zone_tb
    import rsdz_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] stick_x;
        logic [15:0] stick_y;
    } sample_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] strength;
    } stick_out_t;

    localparam int PIPE_DEPTH = 36;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [14:0] cfg_wdata = '0;

    rsdz_sample_if sample ();
    rsdz_result_if result ();

    radial_stick_dead_zone dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sample_t    pending_samples[$];
    stick_out_t expected_outs[$];
    logic [14:0] radius_now = RADIUS_RESET;
    int  error_count = 0;
    int  sample_count = 0;
    int  out_count = 0;
    int  sent_count = 0;
    bit  calm_stretch = 1'b0;
    bit  hold_sender = 1'b0;

    always #2 clk = ~clk;

    // Floor of the square root of a 32-bit sum of squares
    function automatic logic [31:0] floor_root(input logic [31:0] v);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_axis(input logic signed [15:0] a,
                                              input logic [31:0] root);
        longint q;
        if (root == 0)
            return 16'd0;
        q = (longint'(a) * 32768) / longint'(root);
        if (q > 32767)
            q = 32767;
        if (q < -32767)
            q = -32767;
        return q[15:0];
    endfunction

    function automatic stick_out_t dead_zone_predict(input sample_t s,
                                                     input logic [14:0] dz);
        stick_out_t o;
        longint x;
        longint y;
        longint sq;
        longint m;
        longint st;
        logic [31:0] root;
        x = longint'($signed(s.stick_x));
        y = longint'($signed(s.stick_y));
        sq = x * x + y * y;
        root = floor_root(sq[31:0]);
        st = 0;
        if (sq > longint'(dz) * dz)
        begin
            m = (root > 32767) ? 32767 : root;
            if (m > dz && dz != 15'd32767)
                st = ((m - dz) * 32768) / (32767 - dz);
        end
        o.pad = s.pad;
        o.dir_x = unit_axis(s.stick_x, root);
        o.dir_y = unit_axis(s.stick_y, root);
        o.strength = st[15:0];
        return o;
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 40)) - 16'd20;
            3, 4: return 16'($urandom_range(0, 16000)) - 16'd8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit idle_roll();
        return !calm_stretch && ($urandom_range(0, 99) < 14);
    endfunction

    // Driver: advance the sample queue on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample.valid <= 1'b0;
            sample.pad <= '0;
            sample.stick_x <= '0;
            sample.stick_y <= '0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                expected_outs.push_back(dead_zone_predict(
                    {sample.pad, sample.stick_x, sample.stick_y}, radius_now));
                sent_count++;
            end
            if ((!sample.valid || sample.ready) )
            begin
                if (pending_samples.size() != 0 && !hold_sender && !idle_roll())
                begin
                    sample_t s;
                    s = pending_samples.pop_front();
                    sample.valid <= 1'b1;
                    sample.pad <= s.pad;
                    sample.stick_x <= s.stick_x;
                    sample.stick_y <= s.stick_y;
                end
                else
                    sample.valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure and in-order comparison
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_outs.size() == 0)
                begin
                    $error("unexpected result pad=%0d", result.pad_out);
                    error_count++;
                end
                else
                begin
                    stick_out_t e;
                    e = expected_outs.pop_front();
                    out_count++;
                    if (result.pad_out !== e.pad)
                    begin
                        $error("pad_out exp %0d got %0d", e.pad, result.pad_out);
                        error_count++;
                    end
                    if (result.dir_x !== e.dir_x)
                    begin
                        $error("dir_x exp %0d got %0d", $signed(e.dir_x),
                               $signed(result.dir_x));
                        error_count++;
                    end
                    if (result.dir_y !== e.dir_y)
                    begin
                        $error("dir_y exp %0d got %0d", $signed(e.dir_y),
                               $signed(result.dir_y));
                        error_count++;
                    end
                    if (result.strength !== e.strength)
                    begin
                        $error("strength exp %0d got %0d", e.strength,
                               result.strength);
                        error_count++;
                    end
                end
            end
            result.ready <= !idle_roll();
        end
    end

    task automatic queue_sample(input logic [1:0] p, input logic [15:0] x,
                                input logic [15:0] y);
        pending_samples.push_back('{p, x, y});
        sample_count++;
    endtask

    // Drain everything in flight, then let the pipeline settle
    task automatic wait_drained();
        while (pending_samples.size() != 0 || sample.valid ||
               expected_outs.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic set_radius(input logic [14:0] r);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
        radius_now = r;
    endtask

    task automatic queue_random(input int n);
        repeat (n)
            queue_sample(2'($urandom), rand_axis(), rand_axis());
    endtask

    initial
    begin
        logic [14:0] radii[5];
        radii = '{15'd0, 15'd32766, 15'd1, 15'd32767, 15'd100};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero vector, full scale axes, boundary of the reset radius
        queue_sample(2'd0, 16'd0, 16'd0);
        queue_sample(2'd1, 16'h8000, 16'd0);
        queue_sample(2'd2, 16'd0, 16'h8000);
        queue_sample(2'd3, 16'h7FFF, 16'd0);
        queue_sample(2'd0, 16'h8000, 16'h8000);
        queue_sample(2'd1, 16'h7FFF, 16'h7FFF);
        queue_sample(2'd2, 16'h7FFF, 16'h8000);
        queue_sample(2'd3, 16'd7849, 16'd0);
        queue_sample(2'd0, 16'd7849, 16'd1);
        queue_sample(2'd1, 16'd7850, 16'd0);
        queue_sample(2'd2, 16'hFFFF, 16'hFFFF);
        queue_sample(2'd3, 16'd1, 16'd0);
        queue_sample(2'd0, 16'd3, 16'd4);
        queue_sample(2'd1, 16'd5000, 16'd6000);
        wait_drained();

        // Sweep the radius through a set of values including both extremes
        foreach (radii[i])
        begin
            set_radius(radii[i]);
            queue_sample(2'd0, 16'(radii[i]), 16'd0);
            queue_sample(2'd1, 16'(radii[i]), 16'd1);
            queue_sample(2'd2, 16'h8000, 16'h8000);
            queue_random(60);
            wait_drained();
        end

        // Random radius, long calm stretch, then a pause until fully drained
        set_radius(15'($urandom_range(0, 32766)));
        calm_stretch = 1'b1;
        queue_random(200);
        wait_drained();
        calm_stretch = 1'b0;
        queue_random(150);
        while (pending_samples.size() > 75)
            @(posedge clk);
        hold_sender = 1'b1;
        while (sample.valid || expected_outs.size() != 0)
            @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();

        set_radius(RADIUS_RESET);
        queue_random(150);
        wait_drained();

        $display("covered %0d samples, %0d results, radii 0..32767 incl. reset",
                 sample_count, out_count);
        if (error_count == 0)
            $display("radial_stick_dead_zone_tb: clean");
        else
            $display("radial_stick_dead_zone_tb: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("radial_stick_dead_zone_tb: errors");
        $finish;
    end
endmodule
